### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clock, held off while in reset
`define UIFE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("uife assertion failed");

// check that holds in the cycle after its trigger
`define UIFE_ASSERT_NEXT(label, ante, cons) \
    `UIFE_ASSERT(label, (ante) |=> (cons))

`endif

### rtl/uife_pkg.sv
`timescale 1ns / 1ps

package uife_pkg;

    // item kinds
    localparam logic [2:0] KIND_SERVICE = 3'd0;
    localparam logic [2:0] KIND_PUT     = 3'd1;
    localparam logic [2:0] KIND_GET     = 3'd2;
    localparam logic [2:0] KIND_OPEN    = 3'd3;
    localparam logic [2:0] KIND_CLOSE   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_OPEN     = 3'd1;
    localparam logic [2:0] ST_ALREADY_OPEN = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_EMPTY        = 3'd4;

    // interrupt enable bits
    localparam int         EN_DR_BIT  = 0;
    localparam int         EN_TX_BIT  = 1;
    localparam logic [1:0] EN_DR_MASK = 2'(1 << EN_DR_BIT);
    localparam logic [1:0] EN_ALL     = 2'((1 << EN_DR_BIT) | (1 << EN_TX_BIT));

    typedef struct packed {
        logic [2:0] kind;
        logic       line_data_ready;
        logic       line_tx_empty;
        logic [7:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic       tx_write;
        logic       rx_taken;
        logic       get_valid;
        logic [1:0] int_enable;
        logic [2:0] status;
        logic       rx_wake;
        logic       tx_wake;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_ring_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_status;

endpackage

### rtl/uife_stream_if.sv
`timescale 1ns / 1ps

interface uife_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/uart_interrupt_fifo_engine.sv
`timescale 1ns / 1ps

// Receive and transmit byte buffer for an interrupt-driven 8250-style UART.
// Each transfer on i_in is one event: line service (store the received byte,
// issue the next transmit byte), host put, host get, open or close. Every event
// gives exactly one result on o_out, in the cycle after it is accepted. A new event
// is accepted every cycle as long as the result register is free or being
// emptied in the same cycle, so the sustained rate is one event per clock; that
// figure is set by the single result register and by the registered read port
// of each ring, which delivers the popped byte together with the result.
// Both rings hold BUF_DEPTH bytes; a put into a full ring reports ring full and
// a get from an empty ring reports ring empty rather than waiting. Open empties
// both rings and enables only the data-ready interrupt; close disables both.
// Ring storage is not cleared at reset and needs no clearing pass.

`include "assert_macros.svh"

module uart_interrupt_fifo_engine import uife_pkg::*; #(
    parameter int BUF_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uife_stream_if.sink   i_in,
    uife_stream_if.source o_out
);
    t_in_item     w_in;
    logic         w_acc;

    // control state
    logic         r_open, n_open;
    logic [1:0]   r_enable, n_enable;

    // result register, byte field comes from the ring read ports
    logic         r_out_valid;
    t_out_item    r_res, n_res;

    // ring control before and after gating with the transfer
    t_ring_ctrl   w_rx_req, w_tx_req, w_rx_ctrl, w_tx_ctrl;
    t_ring_status w_rx_st, w_tx_st;
    logic [7:0]   w_rx_rd, w_tx_rd;
    t_out_item    w_out;

    assign w_in       = i_in.payload;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    // event decode
    always_comb begin
        n_open   = r_open;
        n_enable = r_enable;
        w_rx_req = '0;
        w_tx_req = '0;
        n_res    = '0;
        n_res.status = ST_OK;

        unique case (w_in.kind)
            KIND_SERVICE: begin
                if (!r_open) begin
                    n_res.status = ST_NOT_OPEN;
                end else begin
                    // line bits act whatever the enables hold
                    if (w_in.line_data_ready) begin
                        if (w_rx_st.full) begin
                            n_enable[EN_DR_BIT] = 1'b0;
                        end else begin
                            w_rx_req.push  = 1'b1;
                            n_res.rx_taken = 1'b1;
                            n_res.rx_wake  = 1'b1;
                        end
                    end
                    if (w_in.line_tx_empty) begin
                        if (w_tx_st.empty) begin
                            n_enable[EN_TX_BIT] = 1'b0;
                        end else begin
                            w_tx_req.pop   = 1'b1;
                            n_res.tx_write = 1'b1;
                            n_res.tx_wake  = 1'b1;
                        end
                    end
                end
            end
            KIND_PUT: begin
                if (!r_open) begin
                    n_res.status = ST_NOT_OPEN;
                end else begin
                    n_enable[EN_TX_BIT] = 1'b1;
                    if (w_tx_st.full) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_tx_req.push = 1'b1;
                    end
                end
            end
            KIND_GET: begin
                if (!r_open) begin
                    n_res.status = ST_NOT_OPEN;
                end else begin
                    n_enable = EN_ALL;
                    if (w_rx_st.empty) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        w_rx_req.pop    = 1'b1;
                        n_res.get_valid = 1'b1;
                    end
                end
            end
            KIND_OPEN: begin
                if (r_open) begin
                    n_res.status = ST_ALREADY_OPEN;
                end else begin
                    w_rx_req.clear = 1'b1;
                    w_tx_req.clear = 1'b1;
                    n_enable       = EN_DR_MASK;
                    n_open         = 1'b1;
                end
            end
            KIND_CLOSE: begin
                if (!r_open) begin
                    n_res.status = ST_NOT_OPEN;
                end else begin
                    n_enable = '0;
                    n_open   = 1'b0;
                end
            end
            default: begin
                // unused kinds change nothing
            end
        endcase

        n_res.int_enable = n_enable;
    end

    // rings move only on an accepted transfer
    assign w_rx_ctrl = w_acc ? w_rx_req : '0;
    assign w_tx_ctrl = w_acc ? w_tx_req : '0;

    uife_ring #(
        .DEPTH(BUF_DEPTH)
    ) u_rx_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_rx_ctrl),
        .i_push_data(w_in.data_in),
        .o_status   (w_rx_st),
        .o_rd_data  (w_rx_rd)
    );

    uife_ring #(
        .DEPTH(BUF_DEPTH)
    ) u_tx_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_tx_ctrl),
        .i_push_data(w_in.data_in),
        .o_status   (w_tx_st),
        .o_rd_data  (w_tx_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_enable    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_open      <= n_open;
                r_enable    <= n_enable;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    // ring read data only changes on a pop, which only follows a taken result
    always_comb begin
        w_out = r_res;
        if (r_res.tx_write) begin
            w_out.data_out = w_tx_rd;
        end else if (r_res.get_valid) begin
            w_out.data_out = w_rx_rd;
        end else begin
            w_out.data_out = '0;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = w_out;

    // opening a closed buffer leaves only the data-ready interrupt enabled
    `UIFE_ASSERT_NEXT(a_open_sets_dr, w_acc && (w_in.kind == KIND_OPEN) && !r_open,
        r_open && (r_enable == EN_DR_MASK))
    // a get on an empty receive ring reports empty and returns no byte
    `UIFE_ASSERT_NEXT(a_get_empty, w_acc && (w_in.kind == KIND_GET) && r_open && w_rx_st.empty,
        o_out.valid && (o_out.payload.status == ST_EMPTY) && !o_out.payload.get_valid)
    // no interrupt stays enabled while closed
    `UIFE_ASSERT(a_closed_quiet, !r_open |-> (r_enable == '0))

endmodule

### rtl/uife_ring.sv
`timescale 1ns / 1ps

module uife_ring import uife_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ring_ctrl   i_ctrl,
    input  logic [7:0]   i_push_data,
    output t_ring_status o_status,
    output logic [7:0]   o_rd_data
);
    localparam int               PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);

    logic [7:0]       r_mem [DEPTH];
    logic [PTR_W-1:0] r_head, r_tail, n_head, n_tail;
    logic             r_head_ph, r_tail_ph, n_head_ph, n_tail_ph;
    logic [7:0]       r_rd_data;

    // slot index plus a lap bit: equal slots and laps is empty, differing laps is full
    always_comb begin
        n_head    = r_head;
        n_head_ph = r_head_ph;
        n_tail    = r_tail;
        n_tail_ph = r_tail_ph;
        if (i_ctrl.clear) begin
            n_head    = '0;
            n_head_ph = 1'b0;
            n_tail    = '0;
            n_tail_ph = 1'b0;
        end else begin
            if (i_ctrl.pop) begin
                if (r_head == LAST) begin
                    n_head    = '0;
                    n_head_ph = ~r_head_ph;
                end else begin
                    n_head = r_head + 1'b1;
                end
            end
            if (i_ctrl.push) begin
                if (r_tail == LAST) begin
                    n_tail    = '0;
                    n_tail_ph = ~r_tail_ph;
                end else begin
                    n_tail = r_tail + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_head_ph <= 1'b0;
            r_tail    <= '0;
            r_tail_ph <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_head_ph <= n_head_ph;
            r_tail    <= n_tail;
            r_tail_ph <= n_tail_ph;
        end
    end

    // storage: one write port at the tail, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_status.empty = (r_head == r_tail) && (r_head_ph == r_tail_ph);
    assign o_status.full  = (r_head == r_tail) && (r_head_ph != r_tail_ph);
    assign o_rd_data      = r_rd_data;

endmodule

### tb/tb_uart_interrupt_fifo_engine.sv
`timescale 1ns / 1ps

module tb_uart_interrupt_fifo_engine;
    import uife_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int PTR_W       = SLOT_W + 1;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS  = 100;

    // kinds with no meaning to the block
    localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0] KIND_RSVD_MID   = 3'd6;
    localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

    localparam logic [1:0] EN_NONE    = 2'b00;
    localparam logic [1:0] EN_TX_MASK = 2'(1 << EN_TX_BIT);

    typedef enum int {
        TRAFFIC_FILL_RX,
        TRAFFIC_DRAIN_RX,
        TRAFFIC_FILL_TX,
        TRAFFIC_DRAIN_TX,
        TRAFFIC_MIXED
    } t_traffic;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    uife_stream_if #(.t_payload(t_in_item))  in_if ();
    uife_stream_if #(.t_payload(t_out_item)) out_if ();

    uart_interrupt_fifo_engine #(
        .BUF_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // shadow copy of the buffer state
    logic [7:0]       rx_bytes [RING_DEPTH];
    logic [7:0]       tx_bytes [RING_DEPTH];
    logic [PTR_W-1:0] rx_rd, rx_wr, tx_rd, tx_wr;
    logic [1:0]       irq_en;
    logic             port_open;

    t_out_item pending_results[$];
    t_dir_row  directed_rows[$];

    int  mismatches;
    int  cycle_count;
    int  items_sent;
    bit  quiet;
    t_traffic traffic;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, generous against the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_in_item ev(logic [2:0] kind, logic dr, logic te, logic [7:0] data);
        t_in_item it;
        it.kind            = kind;
        it.line_data_ready = dr;
        it.line_tx_empty   = te;
        it.data_in         = data;
        return it;
    endfunction

    function automatic t_out_item res(logic [7:0] dout, logic txw, logic rxt, logic gv,
                                      logic [1:0] en, logic [2:0] st, logic rxwk,
                                      logic txwk);
        t_out_item r;
        r.data_out   = dout;
        r.tx_write   = txw;
        r.rx_taken   = rxt;
        r.get_valid  = gv;
        r.int_enable = en;
        r.status     = st;
        r.rx_wake    = rxwk;
        r.tx_wake    = txwk;
        return r;
    endfunction

    // advance the shadow buffer by one event and return what the block should answer
    function automatic t_out_item predict_event(t_in_item it);
        t_out_item        r;
        logic [PTR_W-1:0] rx_fill;
        logic [PTR_W-1:0] tx_fill;
        r        = '0;
        r.status = ST_OK;
        rx_fill  = rx_wr - rx_rd;
        tx_fill  = tx_wr - tx_rd;
        case (it.kind)
            KIND_SERVICE: begin
                if (!port_open) begin
                    r.status = ST_NOT_OPEN;
                end else begin
                    if (it.line_data_ready) begin
                        // rx full: mask the data-ready interrupt, byte stays in the uart
                        if (rx_fill >= RING_DEPTH) begin
                            irq_en = irq_en & ~EN_DR_MASK;
                        end else begin
                            rx_bytes[rx_wr[SLOT_W-1:0]] = it.data_in;
                            rx_wr      = rx_wr + 1'b1;
                            r.rx_taken = 1'b1;
                            r.rx_wake  = 1'b1;
                        end
                    end
                    if (it.line_tx_empty) begin
                        if (tx_fill == 0) begin
                            irq_en = irq_en & ~EN_TX_MASK;
                        end else begin
                            r.data_out = tx_bytes[tx_rd[SLOT_W-1:0]];
                            tx_rd      = tx_rd + 1'b1;
                            r.tx_write = 1'b1;
                            r.tx_wake  = 1'b1;
                        end
                    end
                end
            end
            KIND_PUT: begin
                if (!port_open) begin
                    r.status = ST_NOT_OPEN;
                end else begin
                    irq_en = irq_en | EN_TX_MASK;
                    if (tx_fill >= RING_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        tx_bytes[tx_wr[SLOT_W-1:0]] = it.data_in;
                        tx_wr = tx_wr + 1'b1;
                    end
                end
            end
            KIND_GET: begin
                if (!port_open) begin
                    r.status = ST_NOT_OPEN;
                end else begin
                    irq_en = EN_ALL;
                    if (rx_fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data_out  = rx_bytes[rx_rd[SLOT_W-1:0]];
                        rx_rd       = rx_rd + 1'b1;
                        r.get_valid = 1'b1;
                    end
                end
            end
            KIND_OPEN: begin
                if (port_open) begin
                    r.status = ST_ALREADY_OPEN;
                end else begin
                    rx_rd     = '0;
                    rx_wr     = '0;
                    tx_rd     = '0;
                    tx_wr     = '0;
                    irq_en    = EN_DR_MASK;
                    port_open = 1'b1;
                end
            end
            KIND_CLOSE: begin
                if (!port_open) begin
                    r.status = ST_NOT_OPEN;
                end else begin
                    irq_en    = EN_NONE;
                    port_open = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.int_enable = irq_en;
        return r;
    endfunction

    // most gaps short, a few long, none at all while quiet
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // random event shaped by the current traffic pattern
    function automatic t_in_item next_event();
        int         r;
        int         pick;
        logic [7:0] data;
        logic       dr;
        logic       te;
        r    = $urandom_range(0, 999);
        pick = $urandom_range(0, 99);
        data = 8'($urandom);
        dr   = 1'($urandom);
        te   = 1'($urandom);
        if (!port_open) begin
            if (r < 700) return ev(KIND_OPEN, dr, te, data);
            return ev(3'($urandom), dr, te, data);
        end
        if (r < 4) return ev(KIND_CLOSE, dr, te, data);
        if (r < 8) return ev(KIND_OPEN, dr, te, data);
        if (r < 14) return ev(3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST)), dr, te, data);
        case (traffic)
            TRAFFIC_FILL_RX: begin
                if (pick < 85) return ev(KIND_SERVICE, 1'b1, pick < 17, data);
                return ev(KIND_GET, dr, te, data);
            end
            TRAFFIC_DRAIN_RX: begin
                if (pick < 85) return ev(KIND_GET, dr, te, data);
                return ev(KIND_SERVICE, dr, te, data);
            end
            TRAFFIC_FILL_TX: begin
                if (pick < 85) return ev(KIND_PUT, dr, te, data);
                return ev(KIND_SERVICE, dr, te, data);
            end
            TRAFFIC_DRAIN_TX: begin
                if (pick < 85) return ev(KIND_SERVICE, pick < 17, 1'b1, data);
                return ev(KIND_PUT, dr, te, data);
            end
            default: begin
                if (pick < 34) return ev(KIND_SERVICE, dr, te, data);
                if (pick < 67) return ev(KIND_PUT, dr, te, data);
                return ev(KIND_GET, dr, te, data);
            end
        endcase
    endfunction

    // offer one event, hold it until the transfer, then queue its expected result
    task automatic send_event(t_in_item it, bit typed, t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = predict_event(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent = items_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result side: random stalls, plus one long hold-off that backs up the input
    initial begin
        int  stall;
        bit  long_hold_done;
        out_if.ready   = 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && items_sent >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                out_if.ready <= 1'b1;
            end
        end
    end

    // compare each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("data_out", int'(got.data_out), int'(want.data_out));
                check_field("tx_write", int'(got.tx_write), int'(want.tx_write));
                check_field("rx_taken", int'(got.rx_taken), int'(want.rx_taken));
                check_field("get_valid", int'(got.get_valid), int'(want.get_valid));
                check_field("int_enable", int'(got.int_enable), int'(want.int_enable));
                check_field("status", int'(got.status), int'(want.status));
                check_field("rx_wake", int'(got.rx_wake), int'(want.rx_wake));
                check_field("tx_wake", int'(got.tx_wake), int'(want.tx_wake));
            end
        end
    end

    initial begin
        int span;
        mismatches    = 0;
        cycle_count   = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        traffic       = TRAFFIC_MIXED;
        rx_rd         = '0;
        rx_wr         = '0;
        tx_rd         = '0;
        tx_wr         = '0;
        irq_en        = EN_NONE;
        port_open     = 1'b0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;

        // closed port, unused kinds, open twice, empty rings, then a short round trip
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b1, 1'b1, 8'hFF), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_NONE, ST_NOT_OPEN, '0, '0)});
        directed_rows.push_back('{ev(KIND_PUT, 1'b0, 1'b0, 8'h00), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_NONE, ST_NOT_OPEN, '0, '0)});
        directed_rows.push_back('{ev(KIND_GET, 1'b1, 1'b0, 8'h80), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_NONE, ST_NOT_OPEN, '0, '0)});
        directed_rows.push_back('{ev(KIND_CLOSE, 1'b0, 1'b1, 8'h01), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_NONE, ST_NOT_OPEN, '0, '0)});
        directed_rows.push_back('{ev(KIND_RSVD_FIRST, 1'b1, 1'b1, 8'hAA), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_NONE, ST_OK, '0, '0)});
        directed_rows.push_back('{ev(KIND_RSVD_LAST, 1'b0, 1'b0, 8'h55), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_NONE, ST_OK, '0, '0)});
        directed_rows.push_back('{ev(KIND_OPEN, 1'b0, 1'b0, 8'h00), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_DR_MASK, ST_OK, '0, '0)});
        directed_rows.push_back('{ev(KIND_OPEN, 1'b1, 1'b1, 8'hFF), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_DR_MASK, ST_ALREADY_OPEN, '0, '0)});
        directed_rows.push_back('{ev(KIND_GET, 1'b0, 1'b0, 8'h00), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_ALL, ST_EMPTY, '0, '0)});
        // transmitter empty with nothing queued masks the tx interrupt
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b0, 1'b1, 8'h00), 1'b1,
                                  res(8'h00, '0, '0, '0, EN_DR_MASK, ST_OK, '0, '0)});
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b0, 1'b0, 8'hFF), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_PUT, 1'b0, 1'b0, 8'hFF), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_PUT, 1'b1, 1'b1, 8'h00), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b1, 1'b1, 8'h00), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b1, 1'b0, 8'hFF), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b0, 1'b1, 8'h7F), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_GET, 1'b0, 1'b0, 8'h00), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_GET, 1'b1, 1'b1, 8'hFF), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_GET, 1'b0, 1'b0, 8'h00), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_RSVD_MID, 1'b1, 1'b0, 8'h3C), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_CLOSE, 1'b0, 1'b0, 8'h00), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_SERVICE, 1'b1, 1'b0, 8'hA5), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_OPEN, 1'b0, 1'b0, 8'h00), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_PUT, 1'b0, 1'b0, 8'h5A), 1'b0, '0});
        directed_rows.push_back('{ev(KIND_CLOSE, 1'b1, 1'b1, 8'hC3), 1'b0, '0});

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_event(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // random traffic in stretches, each with its own pattern and idling
        span = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (span == 0) begin
                span    = $urandom_range(60, 160);
                traffic = t_traffic'($urandom_range(TRAFFIC_FILL_RX, TRAFFIC_MIXED));
                quiet   = ($urandom_range(0, 3) == 0);
            end
            span = span - 1;
            send_event(next_event(), 1'b0, '0);
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
